>>> rtl/ptq_pkg.sv
// ----------------------------------------------------------------------------
// ptq_pkg
// Shared types and constants of the periodic task timer queue.
// ----------------------------------------------------------------------------
package ptq_pkg;

    localparam int MS_W       = 16;
    localparam int TICK_W     = 20;
    localparam int ID_W       = 5;
    localparam int TICK_MUL   = 125;
    localparam int TICK_SHIFT = 3;
    localparam int PROD_W     = MS_W + 7;

    typedef enum logic {
        OP_ADD    = 1'b0,
        OP_EXPIRE = 1'b1
    } t_opcode;

    typedef struct packed {
        logic              opcode;
        logic [MS_W-1:0]   period_ms;
    } t_in;

    typedef struct packed {
        logic              task_valid;
        logic [ID_W-1:0]   task_id;
        logic [TICK_W-1:0] next_delay;
        logic              queue_empty;
        logic              error;
        logic              last;
    } t_out;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_ACCEPT,
        CMD_PERIOD_WR,
        CMD_INS_RD,
        CMD_INS_SHIFT,
        CMD_INS_PLACE,
        CMD_SCAN_INIT,
        CMD_SCAN_RD,
        CMD_SCAN_STEP,
        CMD_SCAN_END,
        CMD_DUE_RD,
        CMD_PER_RD,
        CMD_REINS,
        CMD_NEXT,
        CMD_EMIT_INIT,
        CMD_OUT_ADD,
        CMD_OUT_ERR,
        CMD_OUT_EMPTY,
        CMD_OUT_DUE
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_INS_CHK,
        S_INS_CMP,
        S_OUT_ADD,
        S_RE_NEXT,
        S_RE_CHK,
        S_RE_PER,
        S_RE_SET,
        S_SCAN_RD,
        S_SCAN_STEP,
        S_EM_RD,
        S_EM_OUT,
        S_ERR,
        S_EMPTY
    } t_state;

    typedef struct packed {
        logic is_expire;
        logic table_full;
        logic queue_zero;
        logic k_zero;
        logic ins_shift;
        logic scan_done;
        logic j_zero;
        logic j_one;
        logic out_free;
    } t_stat;

endpackage

>>> rtl/ptq_ctrl.sv
// ----------------------------------------------------------------------------
// ptq_ctrl
// Sequencer of the timer queue: steps add, expiry scan, reinsertion and
// emission, one datapath command a cycle unless waiting on input or output.
// ----------------------------------------------------------------------------
module ptq_ctrl
    import ptq_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (!i_stat.is_expire) begin
                    n_state = i_stat.table_full ? S_ERR : S_INS_CHK;
                end else begin
                    n_state = i_stat.queue_zero ? S_EMPTY : S_SCAN_RD;
                end
            end
            S_INS_CHK: begin
                if (i_stat.k_zero) begin
                    n_state = i_stat.is_expire ? S_RE_NEXT : S_OUT_ADD;
                end else begin
                    n_state = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_stat.ins_shift) begin
                    n_state = S_INS_CHK;
                end else begin
                    n_state = i_stat.is_expire ? S_RE_NEXT : S_OUT_ADD;
                end
            end
            S_OUT_ADD: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            S_RE_NEXT:   n_state = S_RE_CHK;
            S_RE_CHK:    n_state = i_stat.j_zero ? S_EM_RD : S_RE_PER;
            S_RE_PER:    n_state = S_RE_SET;
            S_RE_SET:    n_state = S_INS_CHK;
            S_SCAN_RD:   n_state = i_stat.scan_done ? S_RE_CHK : S_SCAN_STEP;
            S_SCAN_STEP: n_state = S_SCAN_RD;
            S_EM_RD:     n_state = S_EM_OUT;
            S_EM_OUT: begin
                if (i_stat.out_free) n_state = i_stat.j_one ? S_IDLE : S_EM_RD;
            end
            S_ERR, S_EMPTY: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = CMD_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd = CMD_ACCEPT;
            end
            S_DECODE: begin
                if (!i_stat.is_expire) begin
                    if (!i_stat.table_full) o_cmd = CMD_PERIOD_WR;
                end else if (!i_stat.queue_zero) begin
                    o_cmd = CMD_SCAN_INIT;
                end
            end
            S_INS_CHK:   o_cmd = i_stat.k_zero ? CMD_INS_PLACE : CMD_INS_RD;
            S_INS_CMP:   o_cmd = i_stat.ins_shift ? CMD_INS_SHIFT : CMD_INS_PLACE;
            S_OUT_ADD: begin
                if (i_stat.out_free) o_cmd = CMD_OUT_ADD;
            end
            S_RE_NEXT:   o_cmd = CMD_NEXT;
            S_RE_CHK:    o_cmd = i_stat.j_zero ? CMD_EMIT_INIT : CMD_DUE_RD;
            S_RE_PER:    o_cmd = CMD_PER_RD;
            S_RE_SET:    o_cmd = CMD_REINS;
            S_SCAN_RD:   o_cmd = i_stat.scan_done ? CMD_SCAN_END : CMD_SCAN_RD;
            S_SCAN_STEP: o_cmd = CMD_SCAN_STEP;
            S_EM_RD:     o_cmd = CMD_DUE_RD;
            S_EM_OUT: begin
                if (i_stat.out_free) o_cmd = CMD_OUT_DUE;
            end
            S_ERR: begin
                if (i_stat.out_free) o_cmd = CMD_OUT_ERR;
            end
            S_EMPTY: begin
                if (i_stat.out_free) o_cmd = CMD_OUT_EMPTY;
            end
            default: o_cmd = CMD_NONE;
        endcase
    end

endmodule

>>> rtl/ptq_dp.sv
// ----------------------------------------------------------------------------
// ptq_dp
// Datapath of the timer queue: period table, sorted queue memory, due list,
// counters and the result register.
// ----------------------------------------------------------------------------
module ptq_dp
    import ptq_pkg::*;
#(
    parameter int MAX_TASKS = 32
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_in   i_in_data,
    input  logic  i_out_ready,
    output t_stat o_stat,
    output logic  o_out_valid,
    output t_out  o_out_data
);

    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int IW = $clog2(MAX_TASKS);

    typedef struct packed {
        logic [IW-1:0]     id;
        logic [TICK_W-1:0] rem;
    } t_qent;

    t_qent             r_q_mem   [MAX_TASKS];
    logic [IW-1:0]     r_due_mem [MAX_TASKS];
    logic [TICK_W-1:0] r_per_mem [MAX_TASKS];

    logic              r_opcode;
    logic [MS_W-1:0]   r_ms;
    logic [CW-1:0]     r_task_cnt;
    logic [CW-1:0]     r_q_cnt;
    logic [CW-1:0]     r_k;
    logic [CW-1:0]     r_y;
    logic [CW-1:0]     r_keep;
    logic [CW-1:0]     r_nd;
    logic [CW-1:0]     r_j;
    logic [TICK_W-1:0] r_elapsed;
    logic [TICK_W-1:0] r_head;
    logic [IW-1:0]     r_ins_id;
    logic [TICK_W-1:0] r_ins_ticks;
    t_qent             r_q_rd;
    logic [IW-1:0]     r_due_rd;
    logic [TICK_W-1:0] r_per_rd;
    logic              r_out_valid;
    t_out              r_out;

    logic [PROD_W-1:0] prod;
    logic [TICK_W-1:0] ticks;
    logic              q_we;
    logic [IW-1:0]     q_wa;
    t_qent             q_wd;
    logic [CW-1:0]     k_m1;
    logic [CW-1:0]     j_m1;
    logic              scan_due;
    logic [TICK_W-1:0] head_delay;
    logic              out_free;
    logic [IW+4:0]     due_ext;

    assign prod       = PROD_W'(r_ms) * PROD_W'(TICK_MUL);
    assign ticks      = prod[TICK_SHIFT +: TICK_W];
    assign k_m1       = r_k - CW'(1);
    assign j_m1       = r_j - CW'(1);
    assign scan_due   = (r_q_rd.rem <= r_elapsed);
    assign head_delay = (r_q_cnt != '0) ? r_head : '0;
    assign out_free   = !r_out_valid || i_out_ready;
    assign due_ext    = {5'd0, r_due_rd};

    always_comb begin
        q_we = 1'b0;
        q_wa = r_k[IW-1:0];
        q_wd = r_q_rd;
        case (i_cmd)
            CMD_INS_SHIFT: begin
                q_we = 1'b1;
            end
            CMD_INS_PLACE: begin
                q_we    = 1'b1;
                q_wd.id  = r_ins_id;
                q_wd.rem = r_ins_ticks;
            end
            CMD_SCAN_STEP: begin
                q_we     = !scan_due;
                q_wa     = r_keep[IW-1:0];
                q_wd.rem = r_q_rd.rem - r_elapsed;
            end
            default: q_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (q_we) r_q_mem[q_wa] <= q_wd;
        if (i_cmd == CMD_INS_RD) r_q_rd <= r_q_mem[k_m1[IW-1:0]];
        if (i_cmd == CMD_SCAN_RD) r_q_rd <= r_q_mem[r_y[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_SCAN_STEP && scan_due) r_due_mem[r_nd[IW-1:0]] <= r_q_rd.id;
        if (i_cmd == CMD_DUE_RD) r_due_rd <= r_due_mem[j_m1[IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_PERIOD_WR) r_per_mem[r_task_cnt[IW-1:0]] <= ticks;
        if (i_cmd == CMD_PER_RD) r_per_rd <= r_per_mem[r_due_rd];
    end

    // head copy follows every write to the front entry
    always_ff @(posedge i_clk) begin
        if (q_we && q_wa == '0) r_head <= q_wd.rem;
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_ACCEPT: begin
                r_opcode <= i_in_data.opcode;
                r_ms     <= i_in_data.period_ms;
            end
            CMD_PERIOD_WR: begin
                r_ins_id    <= r_task_cnt[IW-1:0];
                r_ins_ticks <= ticks;
                r_k         <= r_q_cnt;
            end
            CMD_INS_SHIFT: r_k <= k_m1;
            CMD_SCAN_INIT: begin
                r_elapsed <= r_head;
                r_y       <= '0;
                r_keep    <= '0;
                r_nd      <= '0;
            end
            CMD_SCAN_STEP: begin
                r_y <= r_y + CW'(1);
                if (scan_due) r_nd <= r_nd + CW'(1);
                else r_keep <= r_keep + CW'(1);
            end
            CMD_SCAN_END:  r_j <= r_nd;
            CMD_PER_RD:    r_ins_id <= r_due_rd;
            CMD_REINS: begin
                r_ins_ticks <= r_per_rd;
                r_k         <= r_q_cnt;
            end
            CMD_NEXT, CMD_OUT_DUE: r_j <= j_m1;
            CMD_EMIT_INIT: r_j <= r_nd;
            default: r_j <= r_j;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_cnt <= '0;
            r_q_cnt    <= '0;
        end else begin
            if (i_cmd == CMD_PERIOD_WR) r_task_cnt <= r_task_cnt + CW'(1);
            if (i_cmd == CMD_INS_PLACE) r_q_cnt <= r_q_cnt + CW'(1);
            else if (i_cmd == CMD_SCAN_END) r_q_cnt <= r_keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd == CMD_OUT_ADD || i_cmd == CMD_OUT_ERR ||
                     i_cmd == CMD_OUT_EMPTY || i_cmd == CMD_OUT_DUE) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_OUT_ADD: begin
                r_out.task_valid  <= 1'b1;
                r_out.task_id     <= due_ext[4:0] & '0 | ID_W'({5'd0, r_ins_id});
                r_out.next_delay  <= r_head;
                r_out.queue_empty <= 1'b0;
                r_out.error       <= 1'b0;
                r_out.last        <= 1'b1;
            end
            CMD_OUT_ERR: begin
                r_out.task_valid  <= 1'b0;
                r_out.task_id     <= '0;
                r_out.next_delay  <= head_delay;
                r_out.queue_empty <= (r_q_cnt == '0);
                r_out.error       <= 1'b1;
                r_out.last        <= 1'b1;
            end
            CMD_OUT_EMPTY: begin
                r_out.task_valid  <= 1'b0;
                r_out.task_id     <= '0;
                r_out.next_delay  <= '0;
                r_out.queue_empty <= 1'b1;
                r_out.error       <= 1'b0;
                r_out.last        <= 1'b1;
            end
            CMD_OUT_DUE: begin
                r_out.task_valid  <= 1'b1;
                r_out.task_id     <= due_ext[4:0];
                r_out.next_delay  <= (r_j == CW'(1)) ? r_head : '0;
                r_out.queue_empty <= 1'b0;
                r_out.error       <= 1'b0;
                r_out.last        <= (r_j == CW'(1));
            end
            default: r_out <= r_out;
        endcase
    end

    assign o_stat.is_expire  = (r_opcode == OP_EXPIRE);
    assign o_stat.table_full = (r_task_cnt >= CW'(MAX_TASKS));
    assign o_stat.queue_zero = (r_q_cnt == '0);
    assign o_stat.k_zero     = (r_k == '0);
    assign o_stat.ins_shift  = (r_q_rd.rem >= r_ins_ticks);
    assign o_stat.scan_done  = (r_y == r_q_cnt);
    assign o_stat.j_zero     = (r_j == '0);
    assign o_stat.j_one      = (r_j == CW'(1));
    assign o_stat.out_free   = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/periodic_task_timer_queue.sv
// ----------------------------------------------------------------------------
// periodic_task_timer_queue
// Periodic task scheduler over a queue sorted by remaining timer ticks.
// ----------------------------------------------------------------------------
// One item at a time. An add checks the table, moves up the queued entries
// with no fewer remaining ticks than the new entry to make room, places it
// and loads its result beat. An add to a full table loads an error beat and
// an expiry on an empty queue loads an empty beat. An expiry scans the
// queued entries, moving the due ones to the due list, then reinserts each
// due task with its period, starts emission and loads one result beat per
// due task. Every access to the queue goes through the single port of the
// queue memory, one entry read or written a cycle. A result beat held off
// by the receiver stalls the sequencer at its next result beat until the
// held one is taken. A new item is taken while the last result beat still
// waits.
module periodic_task_timer_queue
    import ptq_pkg::*;
#(
    parameter int MAX_TASKS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_cmd  cmd;
    t_stat stat;

    ptq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    ptq_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

>>> rtl/ptq_checker.sv
// ----------------------------------------------------------------------------
// ptq_checker
// Port-level checks of the timer queue, bound to the top level.
// ----------------------------------------------------------------------------
module ptq_checker
    import ptq_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again right after a beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed");

    a_error_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.error |-> o_out_data.last && !o_out_data.task_valid)
        else $error("error beat not a lone final beat");

    a_delay_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.last |-> o_out_data.next_delay == '0 &&
        o_out_data.task_valid)
        else $error("inner beat carries delay or no task");

endmodule

bind periodic_task_timer_queue ptq_checker u_ptq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
